// ----- rtl/cac_pkg.sv -----
package cac_pkg;

  // Tick counters and limit registers
  typedef logic [9:0] tick_t;

  // One time field (hours, minutes or seconds) and a full hh:mm:ss value,
  // index 0 = hours, 1 = minutes, 2 = seconds
  typedef logic [5:0] tval_t;
  typedef tval_t [2:0] hms_t;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] fsel_t;

  typedef enum logic [1:0] {
    MODE_RUN        = 2'd0,
    MODE_TIME_EDIT  = 2'd1,
    MODE_ALARM_EDIT = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    KEY_NONE       = 4'd0,
    KEY_EDIT_TIME  = 4'd1,
    KEY_EDIT_ALARM = 4'd2,
    KEY_NEXT_FIELD = 4'd3,
    KEY_ARM        = 4'd4,
    KEY_UP         = 4'd5,
    KEY_STEP_DOWN  = 4'd6,
    KEY_COMMIT     = 4'd7,
    KEY_CANCEL     = 4'd8
  } key_t;

  // Configuration register indexes
  localparam logic CfgIdxTicksPerSecond = 1'b0;
  localparam logic CfgIdxTicksPerBlink  = 1'b1;

  localparam tick_t  TicksPerSecondReset = 10'd1000;
  localparam tick_t  TicksPerBlinkReset  = 10'd500;
  localparam digit_t DigitBlank          = 4'd10;
  localparam tval_t  HourMax             = 6'd23;
  localparam tval_t  MinSecMax           = 6'd59;
  localparam tval_t  NoonHour            = 6'd12;
  localparam fsel_t  FieldHours          = 2'd0;
  localparam fsel_t  FieldSeconds        = 2'd2;
  localparam logic [7:0] LedUpperNibble  = 8'hf0;
  localparam logic [7:0] LedLowerNibble  = 8'h0f;
  localparam logic [7:0] LedAllOff       = 8'hff;
  localparam hms_t   TimeReset           = {6'd55, 6'd59, 6'd23};

  typedef struct packed {
    tick_t ticks_per_second;
    tick_t ticks_per_blink;
  } cfg_t;

  typedef struct packed {
    digit_t [5:0] digits;
    logic         buzzer;
    logic [7:0]   led;
    mode_t        mode;
    logic         armed;
  } res_t;

  // Step a field up, wrapping to zero past its maximum
  function automatic tval_t step_up(tval_t v, tval_t vmax);
    return (v >= vmax) ? '0 : tval_t'(v + 6'd1);
  endfunction

  // Step a field down, wrapping to its maximum below zero
  function automatic tval_t step_down(tval_t v, tval_t vmax);
    return (v == '0 || v > vmax) ? vmax : tval_t'(v - 6'd1);
  endfunction

  // Tens digit by reciprocal multiply: (v * 205) >> 11 is exact for v < 1029
  function automatic digit_t tens_of(tval_t v);
    logic [13:0] prod;
    prod = 14'(v) * 14'd205;
    return digit_t'(prod[13:11]);
  endfunction

  function automatic digit_t ones_of(tval_t v);
    tval_t tens10;
    tens10 = tval_t'(tens_of(v)) * 6'd10;
    return digit_t'(v - tens10);
  endfunction

endpackage

// ----- rtl/cac_in_if.sv -----
interface cac_in_if ();
  logic       valid;
  logic       ready;
  logic       action;
  logic [3:0] key;

  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

// ----- rtl/cac_out_if.sv -----
interface cac_out_if import cac_pkg::*; ();
  logic       valid;
  logic       ready;
  digit_t     digit0;
  digit_t     digit1;
  digit_t     digit2;
  digit_t     digit3;
  digit_t     digit4;
  digit_t     digit5;
  logic       buzzer_on;
  logic [7:0] led_out;
  logic [1:0] mode_now;
  logic       alarm_armed;

  modport source (output valid, digit0, digit1, digit2, digit3, digit4, digit5,
                  buzzer_on, led_out, mode_now, alarm_armed, input ready);
  modport sink   (input valid, digit0, digit1, digit2, digit3, digit4, digit5,
                  buzzer_on, led_out, mode_now, alarm_armed, output ready);
endinterface

// ----- rtl/cac_core.sv -----
module cac_core import cac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       action,
  input  logic [3:0] key,
  input  cfg_t       cfg,
  output res_t       res_nxt
);

  hms_t       cur_r, cur_nxt;
  hms_t       edt_r, edt_nxt;
  hms_t       alm_r, alm_nxt;
  hms_t       eda_r, eda_nxt;
  mode_t      mode_r, mode_nxt;
  fsel_t      fsel_r, fsel_nxt;
  tick_t      sec_cnt_r, sec_cnt_nxt;
  tick_t      blk_cnt_r, blk_cnt_nxt;
  logic       blink_r, blink_nxt;
  logic [7:0] pat_r, pat_nxt;
  logic       armed_r, armed_nxt;
  logic       ring_r, ring_nxt;
  logic       buzz_r, buzz_nxt;
  logic [7:0] led_r, led_nxt;

  logic [10:0] sec_inc, blk_inc;
  fsel_t       sel_cur, sel_new;
  tval_t       sel_max;
  hms_t        shown;

  // Field selection as seen by the step keys (index three folds to seconds)
  assign sel_cur = (fsel_r > FieldSeconds) ? FieldSeconds : fsel_r;
  assign sel_max = (sel_cur == FieldHours) ? HourMax : MinSecMax;
  assign sec_inc = {1'b0, sec_cnt_r} + 11'd1;
  assign blk_inc = {1'b0, blk_cnt_r} + 11'd1;

  // Next state for one transaction
  always_comb begin
    cur_nxt     = cur_r;
    edt_nxt     = edt_r;
    alm_nxt     = alm_r;
    eda_nxt     = eda_r;
    mode_nxt    = mode_r;
    fsel_nxt    = fsel_r;
    sec_cnt_nxt = sec_cnt_r;
    blk_cnt_nxt = blk_cnt_r;
    blink_nxt   = blink_r;
    pat_nxt     = pat_r;
    armed_nxt   = armed_r;
    ring_nxt    = ring_r;
    buzz_nxt    = buzz_r;
    led_nxt     = led_r;
    if (accept) begin
      if (!action) begin
        // Timer tick: seconds counter, then clock advance
        if (sec_inc >= {1'b0, cfg.ticks_per_second}) begin
          sec_cnt_nxt = '0;
          if (cur_r[2] >= MinSecMax) begin
            cur_nxt[2] = '0;
            if (cur_r[1] >= MinSecMax) begin
              cur_nxt[1] = '0;
              cur_nxt[0] = (cur_r[0] >= HourMax) ? '0 : tval_t'(cur_r[0] + 6'd1);
            end else begin
              cur_nxt[1] = tval_t'(cur_r[1] + 6'd1);
            end
          end else begin
            cur_nxt[2] = tval_t'(cur_r[2] + 6'd1);
          end
        end else begin
          sec_cnt_nxt = sec_inc[9:0];
        end
        // Half period: blink phase and LED nibble, chosen by the new hour
        if (blk_inc >= {1'b0, cfg.ticks_per_blink}) begin
          blk_cnt_nxt = '0;
          blink_nxt   = ~blink_r;
          pat_nxt     = pat_r ^ ((cur_nxt[0] >= NoonHour) ? LedUpperNibble : LedLowerNibble);
        end else begin
          blk_cnt_nxt = blk_inc[9:0];
        end
      end else if (key != KEY_NONE) begin
        // Key press: any key silences, then the key's own action
        ring_nxt = 1'b0;
        case (key_t'(key))
          KEY_EDIT_TIME: begin
            edt_nxt  = cur_r;
            mode_nxt = MODE_TIME_EDIT;
          end
          KEY_EDIT_ALARM: begin
            eda_nxt  = alm_r;
            mode_nxt = MODE_ALARM_EDIT;
          end
          KEY_NEXT_FIELD: begin
            if (mode_r == MODE_TIME_EDIT || mode_r == MODE_ALARM_EDIT) begin
              fsel_nxt = (fsel_r >= FieldSeconds) ? FieldHours : fsel_t'(fsel_r + 2'd1);
            end
          end
          KEY_ARM: begin
            armed_nxt = ~armed_r;
          end
          KEY_UP: begin
            if (mode_r == MODE_TIME_EDIT) begin
              edt_nxt[sel_cur] = step_up(edt_r[sel_cur], sel_max);
            end else if (mode_r == MODE_ALARM_EDIT) begin
              eda_nxt[sel_cur] = step_up(eda_r[sel_cur], sel_max);
            end
          end
          KEY_STEP_DOWN: begin
            if (mode_r == MODE_TIME_EDIT) begin
              edt_nxt[sel_cur] = step_down(edt_r[sel_cur], sel_max);
            end else if (mode_r == MODE_ALARM_EDIT) begin
              eda_nxt[sel_cur] = step_down(eda_r[sel_cur], sel_max);
            end
          end
          KEY_COMMIT: begin
            if (mode_r == MODE_TIME_EDIT) begin
              cur_nxt = edt_r;
            end else if (mode_r == MODE_ALARM_EDIT) begin
              alm_nxt = eda_r;
            end
            mode_nxt = MODE_RUN;
          end
          KEY_CANCEL: begin
            mode_nxt = MODE_RUN;
          end
          default: begin
          end
        endcase
      end
      // Alarm check on the updated state
      if (armed_nxt) begin
        if (cur_nxt == alm_nxt) begin
          ring_nxt = 1'b1;
        end
        if (ring_nxt) begin
          buzz_nxt = 1'b1;
          led_nxt  = pat_nxt;
        end
      end else begin
        buzz_nxt = 1'b0;
        led_nxt  = LedAllOff;
      end
    end
  end

  // Result built from the updated state
  assign sel_new = (fsel_nxt > FieldSeconds) ? FieldSeconds : fsel_nxt;

  always_comb begin
    case (mode_nxt)
      MODE_TIME_EDIT:  shown = edt_nxt;
      MODE_ALARM_EDIT: shown = eda_nxt;
      default:         shown = cur_nxt;
    endcase
    for (int i = 0; i < 3; i++) begin
      res_nxt.digits[2*i]   = tens_of(shown[i]);
      res_nxt.digits[2*i+1] = ones_of(shown[i]);
    end
    if ((mode_nxt == MODE_TIME_EDIT || mode_nxt == MODE_ALARM_EDIT) && !blink_nxt) begin
      res_nxt.digits[{sel_new, 1'b0}] = DigitBlank;
      res_nxt.digits[{sel_new, 1'b1}] = DigitBlank;
    end
    res_nxt.buzzer = buzz_nxt;
    res_nxt.led    = led_nxt;
    res_nxt.mode   = mode_nxt;
    res_nxt.armed  = armed_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= TimeReset;
      edt_r     <= '0;
      alm_r     <= '0;
      eda_r     <= '0;
      mode_r    <= MODE_RUN;
      fsel_r    <= FieldHours;
      sec_cnt_r <= '0;
      blk_cnt_r <= '0;
      blink_r   <= 1'b0;
      pat_r     <= '0;
      armed_r   <= 1'b1;
      ring_r    <= 1'b0;
      buzz_r    <= 1'b0;
      led_r     <= LedAllOff;
    end else begin
      cur_r     <= cur_nxt;
      edt_r     <= edt_nxt;
      alm_r     <= alm_nxt;
      eda_r     <= eda_nxt;
      mode_r    <= mode_nxt;
      fsel_r    <= fsel_nxt;
      sec_cnt_r <= sec_cnt_nxt;
      blk_cnt_r <= blk_cnt_nxt;
      blink_r   <= blink_nxt;
      pat_r     <= pat_nxt;
      armed_r   <= armed_nxt;
      ring_r    <= ring_nxt;
      buzz_r    <= buzz_nxt;
      led_r     <= led_nxt;
    end
  end

endmodule

// ----- rtl/clock_alarm_controller.sv -----
// A result goes straight into the result register when that is free, else into
// the skid entry. One transaction per cycle while the skid entry is empty; the
// state update and digit split sit in one pass between the state registers and
// the result register. A two-entry output stage (result register plus skid)
// keeps input open while one result waits. Synchronous active-low reset: clock
// 23:59:55, alarm armed, limits 1000 and 500 ticks, output stage empty.
module clock_alarm_controller import cac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cac_in_if.sink     in_ch,
  cac_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t cfg_r;
  res_t res_nxt;
  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;
  logic accept;

  assign in_ch.ready = ~skid_v_r;
  assign accept      = in_ch.valid & in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second <= TicksPerSecondReset;
      cfg_r.ticks_per_blink  <= TicksPerBlinkReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgIdxTicksPerSecond: cfg_r.ticks_per_second <= cfg_data;
        CfgIdxTicksPerBlink:  cfg_r.ticks_per_blink  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cac_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .action  (in_ch.action),
    .key     (in_ch.key),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  // Output stage: result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res_nxt;
      end
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.digit0      = out_r.digits[0];
  assign out_ch.digit1      = out_r.digits[1];
  assign out_ch.digit2      = out_r.digits[2];
  assign out_ch.digit3      = out_r.digits[3];
  assign out_ch.digit4      = out_r.digits[4];
  assign out_ch.digit5      = out_r.digits[5];
  assign out_ch.buzzer_on   = out_r.buzzer;
  assign out_ch.led_out     = out_r.led;
  assign out_ch.mode_now    = out_r.mode;
  assign out_ch.alarm_armed = out_r.armed;

endmodule
